// ----- hw/rtl/midi_note_trigger_with_auto_release_unit_assert.svh -----
// Assertion helpers shared by the unit's modules.
`ifndef MIDI_NOTE_TRIGGER_WITH_AUTO_RELEASE_UNIT_ASSERT_SVH
`define MIDI_NOTE_TRIGGER_WITH_AUTO_RELEASE_UNIT_ASSERT_SVH

// Explicit clock and active-low reset.
`define MNTR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Default clock clk_i and reset rst_ni.
`define MNTR_ASSERT(lbl, prop, msg) \
  `MNTR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/mntr_pkg.sv -----
`timescale 1ns / 1ps
package mntr_pkg;

  localparam int NoteW    = 7;
  localparam int VelW     = 7;
  localparam int ByteW    = 8;
  localparam int ChanCodeW = 4;
  localparam int MapW     = 56;
  localparam int DelayW   = 16;
  localparam int TimeW    = 32;
  localparam int KindW    = 2;
  localparam int PadW     = 3;
  localparam int ChanW    = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 56;

  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;
  localparam int QCntW    = 3;

  localparam logic [ByteW-1:0]  StatusNoteOn  = 8'h90;
  localparam logic [ByteW-1:0]  StatusNoteOff = 8'h80;
  localparam logic [VelW-1:0]   VelOff        = 7'h00;
  localparam logic [DelayW-1:0] DelayReset    = 16'd100;

  typedef enum logic [KindW-1:0] {
    KIND_TICK     = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2,
    KIND_RAW_OFF  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAD_NOTE_MAP  = 1'd0,
    CFG_RELEASE_DELAY = 1'd1
  } cfg_idx_e;

  // One message command between front and back.
  typedef struct packed {
    logic              reject;
    logic [ByteW-1:0]  status_byte;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   vel;
    logic              last;
  } cmd_t;

endpackage

// ----- hw/rtl/mntr_if.sv -----
`timescale 1ns / 1ps
interface mntr_in_if import mntr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [PadW-1:0]   pad;
  logic [VelW-1:0]   velocity;
  logic [ChanW-1:0]  channel;
  logic [NoteW-1:0]  raw_note;
  logic              connected;

  modport source (output valid, kind, pad, velocity, channel, raw_note, connected,
                  input ready);
  modport sink   (input valid, kind, pad, velocity, channel, raw_note, connected,
                  output ready);
endinterface

interface mntr_out_if import mntr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  midi_byte;
  logic              has_byte;
  logic              status;
  logic              last;

  modport source (output valid, midi_byte, has_byte, status, last, input ready);
  modport sink   (input valid, midi_byte, has_byte, status, last, output ready);
endinterface

// ----- hw/rtl/mntr_front.sv -----
`timescale 1ns / 1ps
module mntr_front import mntr_pkg::*; #(
  parameter int PADS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mntr_in_if.sink             req_i,
  output cmd_t                cmd_o,
  output logic                push_o,
  input  logic                full_i
);

  localparam int IdxW = (PADS > 1) ? $clog2(PADS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic [TimeW-1:0]       now_q;
  logic [PADS-1:0]        active_q;
  logic [TimeW-1:0]       start_q [PADS];
  logic [NoteW-1:0]       note_q  [PADS];
  logic [ChanCodeW-1:0]   chan_q  [PADS];
  logic [MapW-1:0]        map_q;
  logic [DelayW-1:0]      delay_q;
  logic [PADS-1:0]        mask_q;

  kind_e                  kind;
  logic                   accept;
  logic                   pad_ok;
  logic [IdxW-1:0]        pad_idx;
  logic [ChanCodeW-1:0]   cc;
  logic [NoteW-1:0]       map_note;
  logic [PADS-1:0]        due;
  logic [IdxW-1:0]        scan_idx;
  logic [PADS-1:0]        pick;
  logic                   scan_last;
  logic [IdxW-1:0]        rd_idx;
  logic                   note_on_ok;

  assign kind       = kind_e'(req_i.kind);
  assign req_i.ready = (state_q == ST_IDLE) && !full_i;
  assign accept     = req_i.valid && req_i.ready;
  assign pad_ok     = {1'b0, req_i.pad} < (PadW+1)'(PADS);
  assign pad_idx    = req_i.pad[IdxW-1:0];
  assign cc         = ChanCodeW'(req_i.channel - ChanW'(1));
  assign map_note   = map_q[NoteW*req_i.pad +: NoteW];
  assign note_on_ok = accept && (kind == KIND_NOTE_ON) && pad_ok && req_i.connected;

  // Release check over all pads at once; wrapping subtraction on the ms clock.
  always_comb begin
    for (int k = 0; k < PADS; k++) begin
      due[k] = active_q[k] && ((now_q - start_q[k]) > {{(TimeW-DelayW){1'b0}}, delay_q});
    end
  end

  // Lowest pending pad first.
  always_comb begin
    scan_idx = '0;
    for (int k = PADS - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        scan_idx = IdxW'(k);
      end
    end
  end

  assign pick      = PADS'(1) << scan_idx;
  assign scan_last = (mask_q & ~pick) == '0;
  assign rd_idx    = (state_q == ST_SCAN) ? scan_idx : pad_idx;

  always_comb begin
    push_o = 1'b0;
    cmd_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_NOTE_ON: begin
              if (pad_ok) begin
                push_o = 1'b1;
                cmd_o.last = 1'b1;
                if (!req_i.connected) begin
                  cmd_o.reject = 1'b1;
                end else begin
                  cmd_o.status_byte = StatusNoteOn | {4'h0, cc};
                  cmd_o.note        = map_note;
                  cmd_o.vel         = req_i.velocity;
                end
              end
            end
            KIND_NOTE_OFF: begin
              if (pad_ok && active_q[pad_idx]) begin
                push_o            = 1'b1;
                cmd_o.last        = 1'b1;
                cmd_o.status_byte = StatusNoteOff | {4'h0, chan_q[rd_idx]};
                cmd_o.note        = note_q[rd_idx];
                cmd_o.vel         = VelOff;
              end
            end
            KIND_RAW_OFF: begin
              push_o            = 1'b1;
              cmd_o.last        = 1'b1;
              cmd_o.status_byte = StatusNoteOff | {4'h0, cc};
              cmd_o.note        = req_i.raw_note;
              cmd_o.vel         = VelOff;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!full_i) begin
          push_o            = 1'b1;
          cmd_o.last        = scan_last;
          cmd_o.status_byte = StatusNoteOff | {4'h0, chan_q[rd_idx]};
          cmd_o.note        = note_q[rd_idx];
          cmd_o.vel         = VelOff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      now_q    <= '0;
      active_q <= '0;
      for (int k = 0; k < PADS; k++) begin
        start_q[k] <= '0;
      end
      map_q    <= '0;
      delay_q  <= DelayReset;
      mask_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PAD_NOTE_MAP:  map_q   <= cfg_wdata_i[MapW-1:0];
          CFG_RELEASE_DELAY: delay_q <= cfg_wdata_i[DelayW-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_TICK: begin
                now_q   <= now_q + TimeW'(1);
                state_q <= ST_EVAL;
              end
              KIND_NOTE_ON: begin
                if (note_on_ok) begin
                  active_q[pad_idx] <= 1'b1;
                  start_q[pad_idx]  <= now_q;
                end
              end
              KIND_NOTE_OFF: begin
                if (pad_ok) begin
                  active_q[pad_idx] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_EVAL: begin
          mask_q  <= due;
          state_q <= (due != '0) ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (!full_i) begin
            active_q <= active_q & ~pick;
            mask_q   <= mask_q & ~pick;
            if (scan_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Note and channel per pad; meaningful only once the pad has been hit.
  always_ff @(posedge clk_i) begin
    if (note_on_ok) begin
      note_q[pad_idx] <= map_note;
      chan_q[pad_idx] <= cc;
    end
  end

endmodule

// ----- hw/rtl/mntr_fifo.sv -----
`timescale 1ns / 1ps
module mntr_fifo import mntr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = count_q == QCntW'(QDepth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`include "midi_note_trigger_with_auto_release_unit_assert.svh"

  `MNTR_ASSERT(a_no_overflow, push_i |-> !full_o, "command queue overflow")
  `MNTR_ASSERT(a_no_underflow, pop_i |-> !empty_o, "command queue underflow")
  `MNTR_ASSERT(a_count_bound, count_q <= QCntW'(QDepth), "command queue count out of range")

endmodule

// ----- hw/rtl/mntr_back.sv -----
`timescale 1ns / 1ps
module mntr_back import mntr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       empty_i,
  output logic       pop_o,
  mntr_out_if.source rsp_o
);

  typedef enum logic [1:0] {
    POS_STATUS,
    POS_NOTE,
    POS_VEL
  } byte_pos_e;

  logic              busy_q;
  cmd_t              cmd_q;
  byte_pos_e         pos_q;
  logic              out_valid_q;
  logic [ByteW-1:0]  byte_q;
  logic              has_q;
  logic              status_q;
  logic              last_q;

  logic              load;
  logic [ByteW-1:0]  sel_byte;

  assign pop_o = !busy_q && !empty_i;
  assign load  = busy_q && (!out_valid_q || rsp_o.ready);

  always_comb begin
    case (pos_q)
      POS_STATUS: sel_byte = cmd_q.status_byte;
      POS_NOTE:   sel_byte = {1'b0, cmd_q.note};
      POS_VEL:    sel_byte = {1'b0, cmd_q.vel};
      default:    sel_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cmd_q       <= '0;
      pos_q       <= POS_STATUS;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      has_q       <= 1'b0;
      status_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        cmd_q  <= cmd_i;
        busy_q <= 1'b1;
        pos_q  <= POS_STATUS;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        if (cmd_q.reject) begin
          byte_q   <= '0;
          has_q    <= 1'b0;
          status_q <= 1'b1;
          last_q   <= cmd_q.last;
          busy_q   <= 1'b0;
        end else begin
          byte_q   <= sel_byte;
          has_q    <= 1'b1;
          status_q <= 1'b0;
          last_q   <= cmd_q.last && (pos_q == POS_VEL);
          case (pos_q)
            POS_STATUS: pos_q <= POS_NOTE;
            POS_NOTE:   pos_q <= POS_VEL;
            default:    busy_q <= 1'b0;
          endcase
        end
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.midi_byte = byte_q;
  assign rsp_o.has_byte  = has_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.last      = last_q;

`include "midi_note_trigger_with_auto_release_unit_assert.svh"

  `MNTR_ASSERT(a_byte_xor_reject, out_valid_q |-> (has_q != status_q), "result both byte and reject")
  `MNTR_ASSERT(a_pop_when_free, pop_o |-> !busy_q, "command taken while busy")
  `MNTR_ASSERT(a_reject_single, (load && cmd_q.reject) |-> (pos_q == POS_STATUS), "reject mid message")

endmodule

// ----- hw/rtl/midi_note_trigger_with_auto_release_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// req_i     in   valid/ready        kind, pad, velocity, channel, raw_note, connected
// rsp_o     out  valid/ready        midi_byte, has_byte, status, last
// cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_wdata_i
//
// A message leaves as three results; the back end fetches the command from the queue, then
// emits the status, note and velocity bytes in turn. A reject leaves as a single result.
// A tick holds the front end in an evaluation state, then in a scan that releases each due pad,
// and that scan is paced by the 4-entry command queue draining at the back-end rate.
// Note on, note off and raw note off are taken in the front end's idle state when the queue has room.
// Reset clears the ms clock, every pad's active flag and start time, and loads the release
// delay with 100; there is no clearing pass.
// A stalled rsp_o holds its result; the queue lets the front end keep taking items meanwhile, until it is full.
module midi_note_trigger_with_auto_release_unit import mntr_pkg::*; #(
  parameter int PADS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mntr_in_if.sink             req_i,
  mntr_out_if.source          rsp_o
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  mntr_front #(
    .PADS (PADS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .push_o      (push),
    .full_i      (full)
  );

  mntr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (back_cmd),
    .empty_o (empty)
  );

  mntr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (back_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule
